// ===== src/lnce_pkg.sv =====
// Package for the LFSR noise channel: opcode and register offset codes,
// the input transaction struct and the period and length lookup tables.
// No dependencies.
package lnce_pkg;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_TIMER  = 2'd1,
      OP_ENV    = 2'd2,
      OP_LENGTH = 2'd3
   } op_type;

   localparam logic [1:0] REG_ENV    = 2'd0;
   localparam logic [1:0] REG_UNUSED = 2'd1;
   localparam logic [1:0] REG_PERIOD = 2'd2;
   localparam logic [1:0] REG_LENGTH = 2'd3;

   localparam logic [3:0] LEVEL_MAX = 4'd15;

   typedef struct packed {
      op_type     operation;
      logic [1:0] register_offset;
      logic [7:0] write_data;
   } req_item_type;

   function automatic logic [11:0] period_lookup(input logic [3:0] idx);
      logic [11:0] p;
      unique case (idx)
         4'd0:  p = 12'd4;
         4'd1:  p = 12'd8;
         4'd2:  p = 12'd16;
         4'd3:  p = 12'd32;
         4'd4:  p = 12'd64;
         4'd5:  p = 12'd96;
         4'd6:  p = 12'd128;
         4'd7:  p = 12'd160;
         4'd8:  p = 12'd202;
         4'd9:  p = 12'd254;
         4'd10: p = 12'd380;
         4'd11: p = 12'd508;
         4'd12: p = 12'd762;
         4'd13: p = 12'd1016;
         4'd14: p = 12'd2034;
         4'd15: p = 12'd4068;
      endcase
      return p;
   endfunction

   function automatic logic [7:0] length_lookup(input logic [4:0] idx);
      logic [7:0] l;
      unique case (idx)
         5'd0:  l = 8'd10;
         5'd1:  l = 8'd254;
         5'd2:  l = 8'd20;
         5'd3:  l = 8'd2;
         5'd4:  l = 8'd40;
         5'd5:  l = 8'd4;
         5'd6:  l = 8'd80;
         5'd7:  l = 8'd6;
         5'd8:  l = 8'd160;
         5'd9:  l = 8'd8;
         5'd10: l = 8'd60;
         5'd11: l = 8'd10;
         5'd12: l = 8'd14;
         5'd13: l = 8'd12;
         5'd14: l = 8'd26;
         5'd15: l = 8'd14;
         5'd16: l = 8'd12;
         5'd17: l = 8'd16;
         5'd18: l = 8'd24;
         5'd19: l = 8'd18;
         5'd20: l = 8'd48;
         5'd21: l = 8'd20;
         5'd22: l = 8'd96;
         5'd23: l = 8'd22;
         5'd24: l = 8'd192;
         5'd25: l = 8'd24;
         5'd26: l = 8'd72;
         5'd27: l = 8'd26;
         5'd28: l = 8'd16;
         5'd29: l = 8'd28;
         5'd30: l = 8'd32;
         5'd31: l = 8'd30;
      endcase
      return l;
   endfunction

endpackage

// ===== src/lnce_state.sv =====
// Channel state: shift register, period timer, envelope and length counter.
// Updates once per accepted transaction and gives the sample after update.
// Depends on lnce_pkg.
module lnce_state (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  lnce_pkg::req_item_type item,
   input  logic                  channel_enable,
   output logic [3:0]            sample_next
);
   import lnce_pkg::*;

   logic [14:0] shifter_ff,  shifter_in;
   logic        mode_ff,     mode_in;
   logic [11:0] count_ff,    count_in;
   logic [11:0] period_ff,   period_in;
   logic [7:0]  length_ff,   length_in;
   logic        halt_ff,     halt_in;
   logic        const_ff,    const_in;
   logic [3:0]  setting_ff,  setting_in;
   logic        restart_ff,  restart_in;
   logic [3:0]  decay_ff,    decay_in;
   logic [3:0]  divider_ff,  divider_in;
   logic        feedback;

   assign feedback = shifter_ff[0] ^ (mode_ff ? shifter_ff[6] : shifter_ff[1]);

   always_comb begin
      shifter_in = shifter_ff;
      mode_in    = mode_ff;
      count_in   = count_ff;
      period_in  = period_ff;
      length_in  = length_ff;
      halt_in    = halt_ff;
      const_in   = const_ff;
      setting_in = setting_ff;
      restart_in = restart_ff;
      decay_in   = decay_ff;
      divider_in = divider_ff;
      if (item_valid) begin
         unique case (item.operation)
            OP_WRITE: begin
               unique case (item.register_offset)
                  REG_ENV: begin
                     halt_in    = item.write_data[5];
                     const_in   = item.write_data[4];
                     setting_in = item.write_data[3:0];
                  end
                  REG_UNUSED: begin
                  end
                  REG_PERIOD: begin
                     mode_in   = item.write_data[7];
                     period_in = period_lookup(item.write_data[3:0]);
                  end
                  REG_LENGTH: begin
                     if (channel_enable) begin
                        length_in = length_lookup(item.write_data[7:3]);
                     end
                     restart_in = 1'b1;
                  end
               endcase
            end
            OP_TIMER: begin
               if (count_ff == 12'd0) begin
                  count_in   = period_ff;
                  shifter_in = {feedback, shifter_ff[14:1]};
               end else begin
                  count_in = count_ff - 12'd1;
               end
            end
            OP_ENV: begin
               if (restart_ff) begin
                  restart_in = 1'b0;
                  decay_in   = LEVEL_MAX;
                  divider_in = setting_ff;
               end else if (divider_ff == 4'd0) begin
                  divider_in = setting_ff;
                  if (decay_ff != 4'd0) begin
                     decay_in = decay_ff - 4'd1;
                  end else if (halt_ff) begin
                     decay_in = LEVEL_MAX;  // loop mode wraps the decay
                  end
               end else begin
                  divider_in = divider_ff - 4'd1;
               end
            end
            OP_LENGTH: begin
               if (!halt_ff && length_ff != 8'd0) begin
                  length_in = length_ff - 8'd1;
               end
            end
         endcase
      end
   end

   always_comb begin
      if (length_in == 8'd0 || shifter_in[0]) begin
         sample_next = 4'd0;
      end else begin
         sample_next = const_in ? setting_in : decay_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shifter_ff <= 15'd1;
         mode_ff    <= 1'b0;
         count_ff   <= 12'd0;
         period_ff  <= period_lookup(4'd0);
         length_ff  <= 8'd0;
         halt_ff    <= 1'b0;
         const_ff   <= 1'b0;
         setting_ff <= 4'd0;
         restart_ff <= 1'b0;
         decay_ff   <= 4'd0;
         divider_ff <= 4'd0;
      end else begin
         shifter_ff <= shifter_in;
         mode_ff    <= mode_in;
         count_ff   <= count_in;
         period_ff  <= period_in;
         length_ff  <= length_in;
         halt_ff    <= halt_in;
         const_ff   <= const_in;
         setting_ff <= setting_in;
         restart_ff <= restart_in;
         decay_ff   <= decay_in;
         divider_ff <= divider_in;
      end
   end

endmodule

// ===== src/lfsr_noise_channel_with_envelope.sv =====
// Noise channel with a 15-bit LFSR, period timer, decay envelope and length
// counter. Each request is a register write or a timer, envelope or length
// tick; each yields one response transaction with the 4-bit sample after the
// update. One transaction per clock unless stalled: the state update is a single
// register-to-register step, and the sample appears on the response port the
// cycle after acceptance. The output register lets a new request enter while
// the previous sample is being taken. csr_channel_enable is always accepted.
module lfsr_noise_channel_with_envelope (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_operation,
   input  logic [1:0] req_register_offset,
   input  logic [7:0] req_write_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_sample,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_channel_enable
);
   import lnce_pkg::*;

   req_item_type item;
   logic         accept;
   logic [3:0]   sample_next;
   logic         enable_ff,     enable_in;
   logic         rsp_valid_ff,  rsp_valid_in;
   logic [3:0]   rsp_sample_ff, rsp_sample_in;

   assign item.operation       = op_type'(req_operation);
   assign item.register_offset = req_register_offset;
   assign item.write_data      = req_write_data;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   lnce_state u_state (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (accept),
      .item           (item),
      .channel_enable (enable_ff),
      .sample_next    (sample_next)
   );

   always_comb begin
      enable_in     = (csr_valid && csr_ready) ? csr_channel_enable : enable_ff;
      rsp_valid_in  = accept || (rsp_valid_ff && !rsp_ready);
      rsp_sample_in = accept ? sample_next : rsp_sample_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         enable_ff    <= enable_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_sample_ff <= rsp_sample_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

endmodule

// ===== src/lnce_checker.sv =====
// Port-level checks for the noise channel top level, and the bind that
// attaches them. Depends on lfsr_noise_channel_with_envelope.
module lnce_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_sample
);

   // a stalled response keeps its sample
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample))
      else $error("response changed while stalled");

   // every accepted request shows a response next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted transaction produced no response");

   // no new request while a stalled response occupies the output
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request accepted over a stalled response");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind lfsr_noise_channel_with_envelope lnce_checker u_lnce_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_sample (rsp_sample)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for lfsr_noise_channel_with_envelope: directed and random
// request traffic against a behavioral model of the noise channel.
// Depends on lnce_pkg (opcode enum and register offset codes) and the DUT.
module tb_top;
   import lnce_pkg::*;

   localparam int STALL_CYCLES = 100;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_operation = '0;
   logic [1:0] req_register_offset = '0;
   logic [7:0] req_write_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [3:0] rsp_sample;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_channel_enable = 1'b0;

   // channel model state
   logic [14:0] lfsr_q;
   logic        tap_sel;
   logic [11:0] tmr_cnt;
   logic [11:0] tmr_reload;
   logic [7:0]  len_cnt;
   logic        len_halt;
   logic        const_vol;
   logic [3:0]  vol_setting;
   logic        env_start;
   logic [3:0]  env_level;
   logic [3:0]  env_div;
   logic        chan_en;

   logic [11:0] period_tab [16] = '{12'd4, 12'd8, 12'd16, 12'd32, 12'd64, 12'd96,
                                    12'd128, 12'd160, 12'd202, 12'd254, 12'd380,
                                    12'd508, 12'd762, 12'd1016, 12'd2034, 12'd4068};
   logic [7:0]  length_tab [32] = '{8'd10, 8'd254, 8'd20, 8'd2, 8'd40, 8'd4, 8'd80, 8'd6,
                                    8'd160, 8'd8, 8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
                                    8'd12, 8'd16, 8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
                                    8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30};

   logic [3:0] expected_samples [$];
   logic [3:0] want_sample;
   int         error_count = 0;
   int         items_sent = 0;
   int         samples_checked = 0;
   int         send_idle_pct = 11;
   int         recv_idle_pct = 64;
   int         stall_requests = 0;
   int         stall_seen = 0;
   int         stall_left = 0;

   lfsr_noise_channel_with_envelope dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_register_offset (req_register_offset),
      .req_write_data      (req_write_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_sample          (rsp_sample),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_channel_enable  (csr_channel_enable)
   );

   always #1 clock = ~clock;

   function automatic void reset_channel_model();
      lfsr_q      = 15'd1;
      tap_sel     = 1'b0;
      tmr_cnt     = '0;
      tmr_reload  = period_tab[0];
      len_cnt     = '0;
      len_halt    = 1'b0;
      const_vol   = 1'b0;
      vol_setting = '0;
      env_start   = 1'b0;
      env_level   = '0;
      env_div     = '0;
      chan_en     = 1'b0;
   endfunction

   // Applies one request to the model and returns the sample that follows it.
   function automatic logic [3:0] next_sample(input op_type op, input logic [1:0] ofs,
                                              input logic [7:0] data);
      logic fb;
      case (op)
         OP_WRITE: begin
            case (ofs)
               REG_ENV: begin
                  len_halt    = data[5];
                  const_vol   = data[4];
                  vol_setting = data[3:0];
               end
               REG_PERIOD: begin
                  tap_sel    = data[7];
                  tmr_reload = period_tab[data[3:0]];
               end
               REG_LENGTH: begin
                  if (chan_en) len_cnt = length_tab[data[7:3]];
                  env_start = 1'b1;
               end
               default: ;
            endcase
         end
         OP_TIMER: begin
            if (tmr_cnt == 0) begin
               tmr_cnt = tmr_reload;
               fb      = lfsr_q[0] ^ (tap_sel ? lfsr_q[6] : lfsr_q[1]);
               lfsr_q  = {fb, lfsr_q[14:1]};
            end else begin
               tmr_cnt = tmr_cnt - 1'b1;
            end
         end
         OP_ENV: begin
            if (env_start) begin
               env_start = 1'b0;
               env_level = LEVEL_MAX;
               env_div   = vol_setting;
            end else if (env_div == 0) begin
               env_div = vol_setting;
               if (env_level != 0) env_level = env_level - 1'b1;
               else if (len_halt) env_level = LEVEL_MAX;
            end else begin
               env_div = env_div - 1'b1;
            end
         end
         default: begin
            if (!len_halt && len_cnt != 0) len_cnt = len_cnt - 1'b1;
         end
      endcase
      if (len_cnt == 0 || lfsr_q[0]) return 4'd0;
      return const_vol ? vol_setting : env_level;
   endfunction

   task automatic report_mismatch(input string what, input logic [3:0] want,
                                  input logic [3:0] got);
      $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $time);
      error_count++;
   endtask

   task automatic send_request(input op_type op, input logic [1:0] ofs,
                               input logic [7:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_operation       <= op;
      req_register_offset <= ofs;
      req_write_data      <= data;
      do @(posedge clock); while (!req_ready);
      expected_samples.push_back(next_sample(op, ofs, data));
      items_sent++;
   endtask

   task automatic drain_channel();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_enable(input logic en);
      csr_valid          <= 1'b1;
      csr_channel_enable <= en;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      chan_en = en;
   endtask

   // Mostly ticks with writes that keep the length loaded and periods short,
   // so the LFSR and envelope actually move and nonzero samples show up.
   task automatic send_random(input int count);
      op_type     op;
      logic [1:0] ofs;
      logic [7:0] data;
      int         pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         ofs  = 2'($urandom_range(3));
         data = 8'($urandom_range(255));
         if (pick < 25) op = OP_WRITE;
         else if (pick < 60) op = OP_TIMER;
         else if (pick < 85) op = OP_ENV;
         else op = OP_LENGTH;
         if (op == OP_WRITE && ofs == REG_PERIOD && $urandom_range(3) != 0)
            data[3:0] = 4'($urandom_range(3));
         if (op == OP_WRITE && ofs == REG_ENV && $urandom_range(1) != 0)
            data[3:0] = 4'($urandom_range(2));
         send_request(op, ofs, data);
      end
   endtask

   task automatic test_directed_basics();
      write_enable(1'b1);
      send_request(OP_TIMER, 2'd3, 8'hFF);      // tick payload is don't-care
      send_request(OP_WRITE, REG_ENV, 8'h3F);
      send_request(OP_WRITE, REG_UNUSED, 8'hFF);
      send_request(OP_WRITE, REG_PERIOD, 8'h8F);
      send_request(OP_WRITE, REG_LENGTH, 8'h00);
      send_request(OP_ENV, 2'd1, 8'h55);
      send_request(OP_LENGTH, 2'd0, 8'h00);     // halted, count holds
      send_request(OP_WRITE, REG_ENV, 8'h05);
      send_request(OP_LENGTH, 2'd2, 8'hAA);
      send_request(OP_WRITE, REG_PERIOD, 8'h00);
      repeat (3) send_request(OP_TIMER, 2'd0, 8'h00);
      drain_channel();
   endtask

   // Decay runs down to zero, then reloads to full because halt is set.
   task automatic test_envelope_wrap();
      send_request(OP_WRITE, REG_ENV, 8'h20);
      send_request(OP_WRITE, REG_LENGTH, 8'h08);
      repeat (17) send_request(OP_ENV, 2'd0, 8'h00);
      drain_channel();
   endtask

   task automatic test_disabled_load();
      write_enable(1'b0);
      send_request(OP_WRITE, REG_ENV, 8'h1A);
      send_request(OP_WRITE, REG_LENGTH, 8'hF8); // restart only, no load
      send_request(OP_ENV, 2'd3, 8'hFF);
      repeat (2) send_request(OP_LENGTH, 2'd0, 8'h00);
      send_request(OP_TIMER, 2'd1, 8'h01);
      drain_channel();
   endtask

   task automatic test_random_traffic(input logic en, input int s_pct, input int r_pct,
                                      input int count);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      write_enable(en);
      send_random(count);
      drain_channel();
   endtask

   // Receiver stops for a long stretch while requests keep coming.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_requests++;
      send_random(40);
      drain_channel();
   endtask

   always @(posedge clock) begin
      if (stall_seen != stall_requests) begin
         stall_seen = stall_requests;
         stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_samples.size() == 0) begin
            report_mismatch("sample with no request pending", 4'd0, rsp_sample);
         end else begin
            want_sample = expected_samples.pop_front();
            if (rsp_sample !== want_sample) report_mismatch("sample", want_sample, rsp_sample);
            samples_checked++;
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      reset_channel_model();
      test_directed_basics();
      test_envelope_wrap();
      test_disabled_load();
      test_random_traffic(1'b1, 11, 64, 700);
      test_random_traffic(1'b0, 64, 11, 250);
      test_random_traffic(1'b1, 64, 11, 450);
      test_random_traffic(1'b1, 0, 0, 600);
      test_backpressure();
      repeat (4) @(posedge clock);
      if (expected_samples.size() != 0)
         report_mismatch("sample never returned", expected_samples[0], 4'd0);
      $display("Covered %0d requests (register writes, timer/envelope/length ticks) with",
               items_sent);
      $display("enable on and off, mixed idling and a long response stall; %0d samples compared",
               samples_checked);
      if (error_count == 0) begin
         $display("lfsr_noise_channel_with_envelope regression: pass");
      end else begin
         $display("lfsr_noise_channel_with_envelope regression: fail");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("Timeout with %0d samples still pending", expected_samples.size());
      $display("lfsr_noise_channel_with_envelope regression: fail");
      $finish;
   end

endmodule
